### hw/rtl/anbs_pkg.sv
package anbs_pkg;

   // Depth of the queue between the classifier and the result sequencer.
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);

   // Status codes of the access unit status result.
   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_NO_START    = 2'd1,
      STAT_NO_NAL_UNIT = 2'd2
   } status_type;

   // Result kinds.
   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   // Results caused by one input byte, in the order they leave the block:
   // an optional held byte, a run of zeros, an optional new byte and an
   // optional status result. All bytes of one descriptor belong to one NAL unit.
   typedef struct packed {
      logic       a_valid;
      logic [7:0] a_byte;
      logic [2:0] zero_cnt;
      logic       b_valid;
      logic [7:0] b_byte;
      logic       first_mark;
      logic       mark_last;
      logic       stat_valid;
      status_type stat;
   } desc_type;

   // Number of payload bytes that a descriptor carries.
   function automatic logic [2:0] desc_bytes(input desc_type d);
      desc_bytes = {2'b00, d.a_valid} + d.zero_cnt + {2'b00, d.b_valid};
   endfunction

   // Number of results that a descriptor carries.
   function automatic logic [2:0] desc_total(input desc_type d);
      desc_total = desc_bytes(d) + {2'b00, d.stat_valid};
   endfunction

endpackage

### hw/rtl/anbs_channels.sv
// Request channel: one byte of the Annex-B stream.
interface anbs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       unit_end;

   modport source (output valid, output stream_byte, output unit_end, input ready);
   modport sink (input valid, input stream_byte, input unit_end, output ready);
endinterface

// Result channel: one payload byte or one access unit status.
interface anbs_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] payload;
   logic       nal_first;
   logic       nal_last;
   logic [1:0] status;
   logic       run_last;

   modport source (output valid, output kind, output payload, output nal_first,
                   output nal_last, output status, output run_last, input ready);
   modport sink (input valid, input kind, input payload, input nal_first,
                 input nal_last, input status, input run_last, output ready);
endinterface

### hw/rtl/anbs_queue.sv
module anbs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  anbs_pkg::desc_type push_desc,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output anbs_pkg::desc_type head_desc
);
   import anbs_pkg::*;

   desc_type                 entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrWidth:0]   count_ff, count_in;

   assign full       = (count_ff == (QueuePtrWidth+1)'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{QueuePtrWidth{1'b0}}, push} - {{QueuePtrWidth{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

### hw/rtl/anbs_front.sv
module anbs_front (
   input  logic               clock,
   input  logic               reset,
   anbs_req_if.sink           req_ch,
   input  logic               queue_full,
   output logic               push,
   output anbs_pkg::desc_type push_desc
);
   import anbs_pkg::*;

   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic [1:0] zero_run_ff, zero_run_in;
   logic       start_seen_ff, start_seen_in;
   logic       unit_open_ff, unit_open_in;
   logic       any_unit_ff, any_unit_in;
   logic       accept;
   logic [7:0] b;
   logic       is_start;
   desc_type   d;
   logic [2:0] nbytes;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.stream_byte;
   assign is_start     = (b == 8'h01) && (zero_run_ff >= 2'd2);

   // Classify the byte and build the descriptor of the results it causes.
   always_comb begin
      d              = '0;
      d.first_mark   = !unit_open_ff;
      d.stat         = STAT_OK;
      held_valid_in  = held_valid_ff;
      held_byte_in   = held_byte_ff;
      zero_run_in    = zero_run_ff;
      start_seen_in  = start_seen_ff;
      unit_open_in   = unit_open_ff;
      any_unit_in    = any_unit_ff;
      nbytes         = '0;

      if (!start_seen_ff) begin
         // Searching for the first start code; leading bytes are dropped.
         if (b == 8'h00) begin
            if (zero_run_ff != 2'd3) zero_run_in = zero_run_ff + 2'd1;
         end else if (is_start) begin
            start_seen_in = 1'b1;
            zero_run_in   = '0;
            held_valid_in = 1'b0;
            unit_open_in  = 1'b0;
         end else begin
            zero_run_in = '0;
         end
         if (req_ch.unit_end) begin
            if (start_seen_in) begin
               d.mark_last = 1'b1;
               d.stat      = STAT_NO_NAL_UNIT;
            end else begin
               d.stat = STAT_NO_START;
            end
            d.stat_valid = 1'b1;
         end
      end else if (b == 8'h00) begin
         if (zero_run_ff != 2'd3) begin
            // Zero joins the held run.
            zero_run_in = zero_run_ff + 2'd1;
            if (req_ch.unit_end) begin
               d.a_valid  = held_valid_ff;
               d.a_byte   = held_byte_ff;
               d.zero_cnt = {1'b0, zero_run_in};
            end
         end else begin
            // Fourth zero: release the held byte, oldest zero becomes held.
            d.a_valid     = held_valid_ff;
            d.a_byte      = held_byte_ff;
            held_byte_in  = 8'h00;
            held_valid_in = 1'b1;
            if (req_ch.unit_end) d.zero_cnt = 3'd4;
         end
      end else if (is_start) begin
         // Start code closes the current unit; the next unit starts unopened.
         d.a_valid     = held_valid_ff;
         d.a_byte      = held_byte_ff;
         d.mark_last   = 1'b1;
         held_valid_in = 1'b0;
         held_byte_in  = 8'h00;
         zero_run_in   = '0;
         unit_open_in  = 1'b0;
      end else begin
         // Ordinary byte: release held byte and zeros, hold the new byte.
         d.a_valid     = held_valid_ff;
         d.a_byte      = held_byte_ff;
         d.zero_cnt    = {1'b0, zero_run_ff};
         zero_run_in   = '0;
         held_byte_in  = b;
         held_valid_in = 1'b1;
         if (req_ch.unit_end) begin
            d.b_valid = 1'b1;
            d.b_byte  = b;
         end
      end

      nbytes = desc_bytes(d);
      if (nbytes != '0) begin
         any_unit_in = 1'b1;
         if (!(start_seen_ff && is_start)) unit_open_in = 1'b1;
      end

      if (req_ch.unit_end) begin
         // Close the access unit and report its status.
         if (start_seen_ff) begin
            d.mark_last  = 1'b1;
            d.stat_valid = 1'b1;
            d.stat       = any_unit_in ? STAT_OK : STAT_NO_NAL_UNIT;
         end
         held_valid_in = 1'b0;
         held_byte_in  = 8'h00;
         zero_run_in   = '0;
         start_seen_in = 1'b0;
         unit_open_in  = 1'b0;
         any_unit_in   = 1'b0;
      end
   end

   assign push      = accept && (desc_total(d) != '0);
   assign push_desc = d;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_byte_ff  <= '0;
         zero_run_ff   <= '0;
         start_seen_ff <= 1'b0;
         unit_open_ff  <= 1'b0;
         any_unit_ff   <= 1'b0;
      end else if (accept) begin
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
         zero_run_ff   <= zero_run_in;
         start_seen_ff <= start_seen_in;
         unit_open_ff  <= unit_open_in;
         any_unit_ff   <= any_unit_in;
      end
   end

endmodule

### hw/rtl/anbs_back.sv
module anbs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  anbs_pkg::desc_type head_desc,
   output logic              pop,
   anbs_rsp_if.source        rsp_ch
);
   import anbs_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_kind_ff, out_kind_in;
   logic [7:0] out_payload_ff, out_payload_in;
   logic       out_first_ff, out_first_in;
   logic       out_last_ff, out_last_in;
   logic [1:0] out_status_ff, out_status_in;
   logic       out_run_last_ff, out_run_last_in;
   logic       slot_free;
   logic       emit;
   logic [2:0] na, nz, nb, total;
   logic       is_byte;

   assign slot_free = !out_valid_ff || rsp_ch.ready;
   assign emit      = slot_free && head_valid;

   // Select the result at the current position of the head descriptor.
   always_comb begin
      na      = {2'b00, head_desc.a_valid};
      nz      = na + head_desc.zero_cnt;
      nb      = nz + {2'b00, head_desc.b_valid};
      total   = nb + {2'b00, head_desc.stat_valid};
      is_byte = (idx_ff < nb);

      out_kind_in    = is_byte ? KIND_PAYLOAD : KIND_STATUS;
      out_status_in  = is_byte ? STAT_OK : head_desc.stat;
      out_first_in   = head_desc.first_mark && is_byte && (idx_ff == '0);
      out_last_in    = head_desc.mark_last && is_byte && (idx_ff == nb - 3'd1);
      out_run_last_in = (idx_ff == total - 3'd1);
      priority if (idx_ff < na) begin
         out_payload_in = head_desc.a_byte;
      end else if (idx_ff < nz) begin
         out_payload_in = 8'h00;
      end else if (idx_ff < nb) begin
         out_payload_in = head_desc.b_byte;
      end else begin
         out_payload_in = 8'h00;
      end

      pop    = emit && out_run_last_in;
      idx_in = idx_ff;
      if (emit) idx_in = out_run_last_in ? 3'd0 : idx_ff + 3'd1;

      out_valid_in = out_valid_ff;
      if (slot_free) out_valid_in = head_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         out_kind_ff     <= out_kind_in;
         out_payload_ff  <= out_payload_in;
         out_first_ff    <= out_first_in;
         out_last_ff     <= out_last_in;
         out_status_ff   <= out_status_in;
         out_run_last_ff <= out_run_last_in;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.kind      = out_kind_ff;
   assign rsp_ch.payload   = out_payload_ff;
   assign rsp_ch.nal_first = out_first_ff;
   assign rsp_ch.nal_last  = out_last_ff;
   assign rsp_ch.status    = out_status_ff;
   assign rsp_ch.run_last  = out_run_last_ff;

endmodule

### hw/rtl/annexb_nal_splitter_top.sv
// Annex-B start code parser: takes one byte of an access unit per cycle (unit_end on
// its last byte), strips 00 00 01 and 00 00 00 01 start codes and returns the NAL unit
// bytes with first and last marks, then one status result per access unit. The front
// classifier accepts a byte in every cycle while its four-entry descriptor queue has
// room; each byte causes zero to six results, which the back sequencer sends one per
// cycle from an output register while the receiver is ready, so the sustained rate is
// one byte per cycle as long as the average number of results per byte stays at or
// below one. The last payload byte of a unit appears only once the next start code or
// the end of the access unit is seen, since one byte and up to three zeros are held
// back. A byte's results pass through the descriptor queue and then the output register.
module annexb_nal_splitter_top (
   input  logic      clock,
   input  logic      reset,
   anbs_req_if.sink  req_ch,
   anbs_rsp_if.source rsp_ch
);
   import anbs_pkg::*;

   logic     push;
   desc_type push_desc;
   logic     queue_full;
   logic     pop;
   logic     head_valid;
   desc_type head_desc;

   anbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_desc  (push_desc)
   );

   anbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   anbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

### verif/tb_annexb_nal_splitter_top.sv
module tb_annexb_nal_splitter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import anbs_pkg::*;

   localparam int RandomItems = 236;
   localparam int CycleLimit = 200000;
   localparam int MaxPrinted = 100;
   localparam logic [7:0] StartCodeEnd = 8'h01;

   // One result as the block should return it.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload;
      logic       nal_first;
      logic       nal_last;
      status_type status;
      logic       run_last;
   } au_result_type;

   // One row of the directed part; when pinned is set, the row must give exactly
   // one status result with the code in pinned_stat.
   typedef struct packed {
      logic [7:0] stream_byte;
      logic       unit_end;
      logic       pinned;
      status_type pinned_stat;
   } directed_row_type;

   localparam int DirectedRows = 23;

   logic clock = 1'b0;
   logic reset;

   anbs_req_if req_ch();
   anbs_rsp_if rsp_ch();

   annexb_nal_splitter_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Parser state of the predictor.
   logic [7:0] hold_byte;
   logic       hold_vld;
   logic [1:0] zero_cnt;
   logic       synced;
   logic       nal_open;
   logic       au_has_nal;

   au_result_type nal_expect_q[$];
   int            mismatch_cnt = 0;
   int unsigned   cycle_cnt = 0;
   int            req_idle_pct = 0;
   int            rsp_idle_pct = 0;
   int            rand_items = 0;

   directed_row_type directed_rows [DirectedRows] = '{
      // A lone byte and a lone zero: no start code at all.
      '{8'hFF, 1'b1, 1'b1, STAT_NO_START},
      '{8'h00, 1'b1, 1'b1, STAT_NO_START},
      // Three-byte start code at the very end: no NAL unit.
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h01, 1'b1, 1'b1, STAT_NO_NAL_UNIT},
      // Four-byte start code at the very end: no NAL unit.
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h01, 1'b1, 1'b1, STAT_NO_NAL_UNIT},
      // Leading junk, a unit with a long zero run, a four-byte code with extra
      // zeros, and a last unit that ends in a trailing zero.
      '{8'h7F, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h01, 1'b0, 1'b0, STAT_OK},
      '{8'hFF, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b0, 1'b0, STAT_OK},
      '{8'h01, 1'b0, 1'b0, STAT_OK},
      '{8'h80, 1'b0, 1'b0, STAT_OK},
      '{8'h00, 1'b1, 1'b0, STAT_OK}
   };

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Cycle counter and run limit.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // The receiver stalls at random.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Prints one line per mismatch up to a cap and counts all of them.
   task automatic report_mismatch(input string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= MaxPrinted) begin
         $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
      end
   endtask

   // Appends one expected result at the tail of the expectation queue.
   function automatic void add_expect(input au_result_type r);
      nal_expect_q.insert(nal_expect_q.size(), r);
   endfunction

   function automatic void clear_parser();
      hold_byte = 8'h00;
      hold_vld = 1'b0;
      zero_cnt = 2'd0;
      synced = 1'b0;
      nal_open = 1'b0;
      au_has_nal = 1'b0;
   endfunction

   function automatic void emit_nal_byte(input logic [7:0] value, input logic last);
      au_result_type r;
      r.kind = KIND_PAYLOAD;
      r.payload = value;
      r.nal_first = !nal_open;
      r.nal_last = last;
      r.status = STAT_OK;
      r.run_last = 1'b0;
      add_expect(r);
      nal_open = 1'b1;
      au_has_nal = 1'b1;
   endfunction

   // Works out the results of one accepted byte and queues them.
   function automatic void split_predict(input logic [7:0] b, input logic unit_end);
      au_result_type r;
      int            n0;
      int            cnt;
      int            k;
      int            i;
      n0 = nal_expect_q.size();
      if (!synced) begin
         // Hunting for the first start code; zero_cnt tracks the zero run.
         if (b == 8'h00) begin
            if (zero_cnt != 2'd3) zero_cnt++;
         end else if (b == StartCodeEnd && zero_cnt >= 2'd2) begin
            synced = 1'b1;
            zero_cnt = 2'd0;
            hold_vld = 1'b0;
            nal_open = 1'b0;
         end else begin
            zero_cnt = 2'd0;
         end
      end else if (b == 8'h00) begin
         // A fourth zero pushes the held byte out and takes its place.
         if (zero_cnt != 2'd3) begin
            zero_cnt++;
         end else begin
            if (hold_vld) emit_nal_byte(hold_byte, 1'b0);
            hold_byte = 8'h00;
            hold_vld = 1'b1;
         end
      end else if (b == StartCodeEnd && zero_cnt >= 2'd2) begin
         // Start code: the held byte closes the current unit.
         if (hold_vld) emit_nal_byte(hold_byte, 1'b1);
         hold_vld = 1'b0;
         hold_byte = 8'h00;
         zero_cnt = 2'd0;
         nal_open = 1'b0;
      end else begin
         if (hold_vld) emit_nal_byte(hold_byte, 1'b0);
         for (i = 0; i < zero_cnt; i++) emit_nal_byte(8'h00, 1'b0);
         zero_cnt = 2'd0;
         hold_byte = b;
         hold_vld = 1'b1;
      end

      if (unit_end) begin
         // Flush what is held, the final byte marked last, then the status.
         if (synced) begin
            cnt = int'(hold_vld) + int'(zero_cnt);
            k = 0;
            if (hold_vld) begin
               emit_nal_byte(hold_byte, k == cnt - 1);
               k++;
            end
            for (i = 0; i < zero_cnt; i++) begin
               emit_nal_byte(8'h00, k == cnt - 1);
               k++;
            end
            r.status = au_has_nal ? STAT_OK : STAT_NO_NAL_UNIT;
         end else begin
            r.status = STAT_NO_START;
         end
         r.kind = KIND_STATUS;
         r.payload = 8'h00;
         r.nal_first = 1'b0;
         r.nal_last = 1'b0;
         r.run_last = 1'b0;
         add_expect(r);
         clear_parser();
      end

      if (nal_expect_q.size() > n0) nal_expect_q[nal_expect_q.size() - 1].run_last = 1'b1;
   endfunction

   // Sends one request and records its expected results once it is accepted.
   task automatic send_req(input logic [7:0] b, input logic unit_end, input logic pinned,
                           input status_type pinned_stat);
      au_result_type r;
      int            n0;
      if ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.stream_byte <= b;
      req_ch.unit_end <= unit_end;
      do @(posedge clock); while (!req_ch.ready);
      n0 = nal_expect_q.size();
      split_predict(b, unit_end);
      if (pinned) begin
         while (nal_expect_q.size() > n0) void'(nal_expect_q.pop_back());
         r.kind = KIND_STATUS;
         r.payload = 8'h00;
         r.nal_first = 1'b0;
         r.nal_last = 1'b0;
         r.status = pinned_stat;
         r.run_last = 1'b1;
         add_expect(r);
      end
   endtask

   // Content byte of a NAL unit, biased toward zeros and start code look-alikes.
   function automatic logic [7:0] nal_content_byte();
      int pick;
      pick = $urandom_range(9);
      if (pick <= 2) return 8'h00;
      if (pick == 3) return StartCodeEnd;
      if (pick == 4) return 8'h03;
      return 8'($urandom_range(255));
   endfunction

   // Builds one access unit and sends it: mostly well formed, some noise and
   // some units cut short.
   task automatic send_access_unit();
      logic [7:0] au_bytes[$];
      int         shape;
      int         nals;
      int         zeros;
      int         len;
      int         i;
      int         j;
      shape = $urandom_range(9);
      if (shape == 0) begin
         len = $urandom_range(8, 1);
         for (i = 0; i < len; i++) au_bytes.insert(au_bytes.size(), 8'($urandom_range(255)));
      end else begin
         if ($urandom_range(3) == 0) begin
            len = $urandom_range(3, 1);
            for (i = 0; i < len; i++) au_bytes.insert(au_bytes.size(), nal_content_byte());
         end
         nals = $urandom_range(3, 1);
         for (i = 0; i < nals; i++) begin
            zeros = ($urandom_range(4) == 0) ? $urandom_range(6, 4) : $urandom_range(3, 2);
            for (j = 0; j < zeros; j++) au_bytes.insert(au_bytes.size(), 8'h00);
            au_bytes.insert(au_bytes.size(), StartCodeEnd);
            len = $urandom_range(6, 0);
            for (j = 0; j < len; j++) au_bytes.insert(au_bytes.size(), nal_content_byte());
         end
         if (shape == 1) begin
            len = $urandom_range(au_bytes.size(), 1);
            while (au_bytes.size() > len) void'(au_bytes.pop_back());
         end
      end
      for (i = 0; i < au_bytes.size(); i++) begin
         send_req(au_bytes[i], i == au_bytes.size() - 1, 1'b0, STAT_OK);
         rand_items++;
      end
   endtask

   // Holds the sender off until every expected result has come.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (nal_expect_q.size() != 0);
   endtask

   // Result checker: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      au_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (nal_expect_q.size() == 0) begin
            report_mismatch("result arrived with nothing expected");
         end else begin
            want = nal_expect_q.pop_front();
            if (rsp_ch.kind !== want.kind)
               report_mismatch($sformatf("kind got %0d want %0d", rsp_ch.kind, want.kind));
            if (rsp_ch.payload !== want.payload)
               report_mismatch($sformatf("payload got %02h want %02h", rsp_ch.payload,
                                         want.payload));
            if (rsp_ch.nal_first !== want.nal_first)
               report_mismatch($sformatf("nal_first got %0d want %0d", rsp_ch.nal_first,
                                         want.nal_first));
            if (rsp_ch.nal_last !== want.nal_last)
               report_mismatch($sformatf("nal_last got %0d want %0d", rsp_ch.nal_last,
                                         want.nal_last));
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d", rsp_ch.status,
                                         want.status));
            if (rsp_ch.run_last !== want.run_last)
               report_mismatch($sformatf("run_last got %0d want %0d", rsp_ch.run_last,
                                         want.run_last));
         end
      end
   end

   // Main sequence.
   initial begin : stimulus
      int phase;
      int i;
      clear_parser();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.stream_byte <= 8'h00;
      req_ch.unit_end <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the first idling mix.
      req_idle_pct = 34;
      rsp_idle_pct = 54;
      for (i = 0; i < DirectedRows; i++) begin
         send_req(directed_rows[i].stream_byte, directed_rows[i].unit_end,
                  directed_rows[i].pinned, directed_rows[i].pinned_stat);
      end

      // Random part in three idling phases; each ends with a full drain.
      for (phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 54 : 0;
         rsp_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 34 : 0;
         while (rand_items < (phase + 1) * RandomItems / 3) send_access_unit();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
